FILE: rtl/wcad_pkg.sv
// ----------------------------------------------------------------------------
// wcad_pkg: shared types and constants of the wall clock display
// Time digit record, message record, request codes and message byte table.
// ----------------------------------------------------------------------------
package wcad_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ZERO   = 2'd1,
        OP_SET    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [1:0] h_tens;
        logic [3:0] h_ones;
        logic [2:0] m_tens;
        logic [3:0] m_ones;
        logic [2:0] s_tens;
        logic [3:0] s_ones;
    } time_t;

    typedef struct packed {
        logic  blank;
        time_t tm;
    } msg_t;

    localparam int MSG_LEN   = 17;
    localparam int IDX_W     = $clog2(MSG_LEN);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MSG_LEN - 1);

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BRK   = 8'h5B;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    function automatic logic [7:0] msg_byte(input msg_t m, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = CH_SPACE;
        case (idx)
            5'd0:  b = CH_ESC;
            5'd1:  b = CH_BRK;
            5'd2:  b = CH_ONE;
            5'd3:  b = CH_SEMI;
            5'd4:  b = CH_SEVEN;
            5'd5:  b = CH_TWO;
            5'd6:  b = CH_F;
            5'd7:  b = m.blank ? CH_SPACE : digit_char({2'b00, m.tm.h_tens});
            5'd8:  b = m.blank ? CH_SPACE : digit_char(m.tm.h_ones);
            5'd9:  b = m.blank ? CH_SPACE : CH_COLON;
            5'd10: b = m.blank ? CH_SPACE : digit_char({1'b0, m.tm.m_tens});
            5'd11: b = m.blank ? CH_SPACE : digit_char(m.tm.m_ones);
            5'd12: b = m.blank ? CH_SPACE : CH_COLON;
            5'd13: b = m.blank ? CH_SPACE : digit_char({1'b0, m.tm.s_tens});
            5'd14: b = m.blank ? CH_SPACE : digit_char(m.tm.s_ones);
            5'd15: b = CH_CR;
            5'd16: b = CH_LF;
            default: b = CH_SPACE;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/wcad_front.sv
// ----------------------------------------------------------------------------
// wcad_front: request decoder and time keeper
// Accepts requests, checks set text, advances the time and queues messages.
// ----------------------------------------------------------------------------
module wcad_front
    import wcad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        req_valid,
    input  logic        q_full,
    input  logic [1:0]  req_op,
    input  logic [71:0] req_text,
    output logic        req_ready,
    output logic        push,
    output msg_t        push_msg
);

    time_t      time_reg, time_next;
    logic       shown_reg, shown_next;
    logic       accept;
    logic [7:0] ch [9];
    logic       text_ok;
    time_t      tick_time;
    logic       s_wrap, m_wrap;

    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            ch[i] = req_text[8*i +: 8];
        end
    end

    always_comb begin
        text_ok = (ch[0] == CH_SPACE)
            && (ch[1] >= CH_ZERO) && (ch[1] <= CH_TWO)
            && (ch[2] >= CH_ZERO) && (ch[2] <= CH_NINE)
            && !((ch[1] == CH_TWO) && (ch[2] > CH_THREE))
            && (ch[3] == CH_COLON) && (ch[6] == CH_COLON)
            && (ch[4] >= CH_ZERO) && (ch[4] <= CH_FIVE)
            && (ch[7] >= CH_ZERO) && (ch[7] <= CH_FIVE)
            && (ch[5] >= CH_ZERO) && (ch[5] <= CH_NINE)
            && (ch[8] >= CH_ZERO) && (ch[8] <= CH_NINE);
    end

    always_comb begin
        tick_time = time_reg;
        s_wrap    = 1'b0;
        m_wrap    = 1'b0;
        if (time_reg.s_ones == 4'd9) begin
            tick_time.s_ones = 4'd0;
            if (time_reg.s_tens == 3'd5) begin
                tick_time.s_tens = 3'd0;
                s_wrap = 1'b1;
            end else begin
                tick_time.s_tens = time_reg.s_tens + 3'd1;
            end
        end else begin
            tick_time.s_ones = time_reg.s_ones + 4'd1;
        end
        if (s_wrap) begin
            if (time_reg.m_ones == 4'd9) begin
                tick_time.m_ones = 4'd0;
                if (time_reg.m_tens == 3'd5) begin
                    tick_time.m_tens = 3'd0;
                    m_wrap = 1'b1;
                end else begin
                    tick_time.m_tens = time_reg.m_tens + 3'd1;
                end
            end else begin
                tick_time.m_ones = time_reg.m_ones + 4'd1;
            end
        end
        if (m_wrap) begin
            if (time_reg.h_tens == 2'd2 && time_reg.h_ones == 4'd3) begin
                tick_time.h_tens = 2'd0;
                tick_time.h_ones = 4'd0;
            end else if (time_reg.h_ones == 4'd9) begin
                tick_time.h_ones = 4'd0;
                tick_time.h_tens = time_reg.h_tens + 2'd1;
            end else begin
                tick_time.h_ones = time_reg.h_ones + 4'd1;
            end
        end
    end

    always_comb begin
        time_next      = time_reg;
        shown_next     = shown_reg;
        push           = 1'b0;
        push_msg.blank = 1'b0;
        if (accept) begin
            case (op_t'(req_op))
                OP_TICK: begin
                    if (shown_reg) begin
                        time_next = tick_time;
                        push      = 1'b1;
                    end
                end
                OP_ZERO: begin
                    time_next  = '0;
                    shown_next = 1'b1;
                    push       = 1'b1;
                end
                OP_SET: begin
                    if (text_ok) begin
                        time_next.h_tens = ch[1][1:0];
                        time_next.h_ones = ch[2][3:0];
                        time_next.m_tens = ch[4][2:0];
                        time_next.m_ones = ch[5][3:0];
                        time_next.s_tens = ch[7][2:0];
                        time_next.s_ones = ch[8][3:0];
                        shown_next       = 1'b1;
                        push             = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    shown_next     = 1'b0;
                    push           = 1'b1;
                    push_msg.blank = 1'b1;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
        push_msg.tm = time_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg  <= '{h_tens: 2'd1, h_ones: 4'd0, m_tens: 3'd1,
                           m_ones: 4'd0, s_tens: 3'd1, s_ones: 4'd0};
            shown_reg <= 1'b0;
        end else begin
            time_reg  <= time_next;
            shown_reg <= shown_next;
        end
    end

endmodule

FILE: rtl/wcad_queue.sv
// ----------------------------------------------------------------------------
// wcad_queue: message queue
// Short first-in first-out buffer of message records between the two halves.
// ----------------------------------------------------------------------------
module wcad_queue
    import wcad_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  msg_t push_msg,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output msg_t head_msg
);

    msg_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_msg   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_msg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/wcad_serial.sv
// ----------------------------------------------------------------------------
// wcad_serial: message serializer
// Sends queued message records one byte per cycle while out_ready holds.
// ----------------------------------------------------------------------------
module wcad_serial
    import wcad_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  msg_t       head_msg,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [7:0] out_data,
    output logic       out_last
);

    back_state_t      state_reg, state_next;
    msg_t             cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;
    logic             can_load;
    logic             at_end;
    logic             emit;

    assign can_load = !valid_reg || out_ready;
    assign at_end   = can_load && (idx_reg == IDX_LAST);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (at_end && !head_valid) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop = head_valid;
            end
            ST_SEND: begin
                emit = can_load;
                pop  = at_end && head_valid;
            end
            default: begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (pop) begin
            cur_next = head_msg;
            idx_next = '0;
        end else if (emit) begin
            idx_next = idx_reg + 1'b1;
        end
        if (can_load) begin
            valid_next = emit;
            data_next  = msg_byte(cur_reg, idx_reg);
            last_next  = (idx_reg == IDX_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

FILE: rtl/wall_clock_with_ascii_display.sv
// ----------------------------------------------------------------------------
// wall_clock_with_ascii_display: time-of-day clock with console message
// Keeps HH:MM:SS and sends cursor escape, time text, CR and LF per request.
//
//   Channel | Ports                            | Contents
//   request | s_tvalid s_tready s_tuser s_tdata| operation, nine set-time chars
//   message | m_tvalid m_tready m_tdata m_tlast| one message byte, final byte
//
// A request is decoded and the time updated in the cycle it is accepted.
// Each message is 17 bytes, sent by the byte serializer; requests
// are taken every cycle while the two-entry message queue has room.
// Reset is synchronous and needs no clearing pass.
// A stalled output holds its byte; the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module wall_clock_with_ascii_display
    import wcad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // lead, hour tens, hour ones, colon, minute tens,
                                   // minute ones, colon, second tens, second ones
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);

    logic push, pop, q_full, head_valid;
    msg_t push_msg, head_msg;

    wcad_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .q_full    (q_full),
        .req_op    (s_tuser),
        .req_text  (s_tdata),
        .req_ready (s_tready),
        .push      (push),
        .push_msg  (push_msg)
    );

    wcad_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_msg   (push_msg),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_msg   (head_msg)
    );

    wcad_serial u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_msg   (head_msg),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

FILE: rtl/wcad_checker.sv
// ----------------------------------------------------------------------------
// wcad_checker: port-level checks of the wall clock display
// Watches message framing and handshakes, and request contents on acceptance.
// ----------------------------------------------------------------------------
module wcad_checker
    import wcad_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    logic at_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            at_start_reg <= m_tlast;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("message byte changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("message valid right after reset");

    a_start_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && at_start_reg |-> m_tdata == CH_ESC)
        else $error("message does not start with the escape byte");

    a_last_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == CH_LF)
        else $error("final message byte is not a line feed");

    a_req_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tuser) && !$isunknown(s_tdata))
        else $error("request accepted with unknown contents");

endmodule

bind wall_clock_with_ascii_display wcad_checker u_wcad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/wall_clock_with_ascii_display_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of wall_clock_with_ascii_display
// Drives tick, zero, set and remove requests on the request stream. A
// scoreboard keeps its own copy of the clock time and display flag, works out
// the 17-byte console message, if any, that each request causes and
// compares every byte taken from the message stream in order. Both sides
// idle at random. The receiver also holds off once for a long stretch,
// and the sender pauses once until every expected byte has arrived.
// ----------------------------------------------------------------------------

import wcad_pkg::*;

class clock_message_board;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    msg_byte_t  awaited_bytes[$];
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    bit         shown;
    int         mismatches;

    function new();
        hours      = 5'd10;
        minutes    = 6'd10;
        seconds    = 6'd10;
        shown      = 1'b0;
        mismatches = 0;
    endfunction

    function int pending_count();
        return awaited_bytes.size();
    endfunction

    // The body holds the eight bytes between the cursor escape and CR LF,
    // the first byte in the lowest bits.
    function void push_message(logic [63:0] body);
        logic [7:0] msg [17];
        msg_byte_t  b;
        msg[0] = CH_ESC;
        msg[1] = CH_BRK;
        msg[2] = CH_ONE;
        msg[3] = CH_SEMI;
        msg[4] = CH_SEVEN;
        msg[5] = CH_TWO;
        msg[6] = CH_F;
        for (int i = 0; i < 8; i++) begin
            msg[7 + i] = body[8*i +: 8];
        end
        msg[15] = CH_CR;
        msg[16] = CH_LF;
        for (int i = 0; i < 17; i++) begin
            b.data = msg[i];
            b.last = (i == 16);
            awaited_bytes.push_back(b);
        end
    endfunction

    function void push_time();
        logic [63:0] body;
        body[7:0]   = CH_ZERO + 8'(hours / 10);
        body[15:8]  = CH_ZERO + 8'(hours % 10);
        body[23:16] = CH_COLON;
        body[31:24] = CH_ZERO + 8'(minutes / 10);
        body[39:32] = CH_ZERO + 8'(minutes % 10);
        body[47:40] = CH_COLON;
        body[55:48] = CH_ZERO + 8'(seconds / 10);
        body[63:56] = CH_ZERO + 8'(seconds % 10);
        push_message(body);
    endfunction

    function bit digit_upto(logic [7:0] c, logic [7:0] top);
        return (c >= CH_ZERO) && (c <= top);
    endfunction

    function bit text_ok(logic [71:0] t);
        if (t[7:0] != CH_SPACE) return 1'b0;
        if (!digit_upto(t[15:8], CH_TWO)) return 1'b0;
        if (t[15:8] == CH_TWO && t[23:16] > CH_THREE) return 1'b0;
        if (t[31:24] != CH_COLON || t[55:48] != CH_COLON) return 1'b0;
        if (!digit_upto(t[39:32], CH_FIVE) || !digit_upto(t[63:56], CH_FIVE)) return 1'b0;
        if (!digit_upto(t[23:16], CH_NINE) || !digit_upto(t[47:40], CH_NINE)
            || !digit_upto(t[71:64], CH_NINE)) return 1'b0;
        return 1'b1;
    endfunction

    // Returns the number of message bytes the request causes.
    function int note_request(op_t op, logic [71:0] text);
        case (op)
            OP_TICK: begin
                if (!shown) return 0;
                seconds = seconds + 6'd1;
                if (seconds >= 6'd60) begin
                    seconds = 6'd0;
                    minutes = minutes + 6'd1;
                end
                if (minutes >= 6'd60) begin
                    minutes = 6'd0;
                    hours   = hours + 5'd1;
                end
                if (hours >= 5'd24) begin
                    hours   = 5'd0;
                    minutes = 6'd0;
                    seconds = 6'd0;
                end
                push_time();
            end
            OP_ZERO: begin
                hours   = 5'd0;
                minutes = 6'd0;
                seconds = 6'd0;
                shown   = 1'b1;
                push_time();
            end
            OP_SET: begin
                if (!text_ok(text)) return 0;
                hours   = 5'((text[15:8] - CH_ZERO) * 10 + (text[23:16] - CH_ZERO));
                minutes = 6'((text[39:32] - CH_ZERO) * 10 + (text[47:40] - CH_ZERO));
                seconds = 6'((text[63:56] - CH_ZERO) * 10 + (text[71:64] - CH_ZERO));
                shown   = 1'b1;
                push_time();
            end
            default: begin
                shown = 1'b0;
                push_message({8{CH_SPACE}});
            end
        endcase
        return 17;
    endfunction

    function void check_byte(logic [7:0] data, logic last);
        msg_byte_t e;
        if (awaited_bytes.size() == 0) begin
            $display("%0t: unexpected message byte, expected none, actual %h last %b",
                     $time, data, last);
            mismatches++;
            return;
        end
        e = awaited_bytes.pop_front();
        if (data !== e.data) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h", $time, e.data, data);
            mismatches++;
        end
        if (last !== e.last) begin
            $display("%0t: last_byte mismatch, expected %b, actual %b", $time, e.last, last);
            mismatches++;
        end
    endfunction

endclass

module wall_clock_with_ascii_display_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PCT    = 37;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // lead, hour tens, hour ones, colon, minute tens,
                            // minute ones, colon, second tens, second ones
    logic [1:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic        m_tlast;

    clock_message_board board = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on;
    int hold_requests;
    int cycles = 0;

    wall_clock_with_ascii_display DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Message side: checks each accepted byte and idles at random.
    initial begin
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                board.check_byte(m_tdata, m_tlast);
            end
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [71:0] time_text(int h, int m, int s);
        logic [71:0] t;
        t[7:0]   = CH_SPACE;
        t[15:8]  = CH_ZERO + 8'(h / 10);
        t[23:16] = CH_ZERO + 8'(h % 10);
        t[31:24] = CH_COLON;
        t[39:32] = CH_ZERO + 8'(m / 10);
        t[47:40] = CH_ZERO + 8'(m % 10);
        t[55:48] = CH_COLON;
        t[63:56] = CH_ZERO + 8'(s / 10);
        t[71:64] = CH_ZERO + 8'(s % 10);
        return t;
    endfunction

    function automatic logic [71:0] random_bytes();
        return {8'($urandom), $urandom, $urandom};
    endfunction

    // Offers one request and returns at the edge that accepts it.
    task automatic send_request(input op_t op, input logic [71:0] text);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= text;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        void'(board.note_request(op, text));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_count() != 0) @(posedge aclk);
    endtask

    initial begin
        int          counted;
        int          pick;
        int          h;
        int          m;
        int          s;
        logic [71:0] t;

        hold_requests <= 0;
        rx_idle_on    <= 1'b1;
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tuser       <= OP_TICK;
        s_tdata       <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: hidden clock, format checks, carries and day wrap.
        send_request(OP_TICK, '0);
        send_request(OP_SET, {72{1'b1}});
        send_request(OP_SET, '0);
        send_request(OP_REMOVE, {72{1'b1}});
        send_request(OP_SET, time_text(23, 59, 59));
        send_request(OP_TICK, '0);
        send_request(OP_SET, time_text(9, 59, 59));
        send_request(OP_TICK, {72{1'b1}});
        send_request(OP_SET, time_text(0, 0, 58));
        send_request(OP_TICK, '0);
        send_request(OP_TICK, '0);
        send_request(OP_SET, time_text(24, 0, 0));
        send_request(OP_SET, time_text(12, 60, 0));
        send_request(OP_SET, time_text(1, 2, 60));
        send_request(OP_SET, time_text(30, 0, 0));
        send_request(OP_SET, time_text(19, 9, 9));
        t = time_text(10, 20, 30);
        t[7:0] = CH_ZERO;
        send_request(OP_SET, t);
        t = time_text(10, 20, 30);
        t[55:48] = CH_SEMI;
        send_request(OP_SET, t);
        t = time_text(10, 20, 30);
        t[23:16] = CH_ZERO - 8'd1;
        send_request(OP_SET, t);
        t = time_text(10, 20, 30);
        t[47:40] = CH_COLON;
        send_request(OP_SET, t);
        send_request(OP_ZERO, {72{1'b1}});
        send_request(OP_REMOVE, '0);
        send_request(OP_TICK, '0);
        send_request(OP_ZERO, '0);
        send_request(OP_TICK, '0);

        // Random part: mostly well-formed requests with random content.
        counted = 0;
        while (counted < 205) begin
            if (counted == 60) begin
                hold_requests <= hold_requests + 1;
            end
            if (counted == 90) begin
                tx_idle_on = 1'b0;
                rx_idle_on <= 1'b0;
            end
            if (counted == 130) begin
                tx_idle_on = 1'b1;
                rx_idle_on <= 1'b1;
            end
            if (counted == 170) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            h = $urandom_range(0, 23);
            m = $urandom_range(0, 59);
            s = $urandom_range(0, 59);
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 1)) h = 23;
                m = 59;
                s = $urandom_range(57, 59);
            end
            t = time_text(h, m, s);
            if (pick < 50) begin
                send_request(OP_TICK, random_bytes());
            end else if (pick < 65) begin
                send_request(OP_SET, t);
            end else if (pick < 72) begin
                send_request(OP_ZERO, random_bytes());
            end else if (pick < 80) begin
                send_request(OP_REMOVE, random_bytes());
            end else if (pick < 92) begin
                t[8*$urandom_range(0, 8) +: 8] = 8'($urandom);
                send_request(OP_SET, t);
            end else begin
                send_request(op_t'($urandom_range(0, 3)), random_bytes());
            end
            counted++;
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (board.pending_count() != 0) begin
            $display("%0t: %0d message bytes never arrived, expected 0, actual %0d",
                     $time, board.pending_count(), board.pending_count());
            board.mismatches++;
        end
        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
